>>> src/cdg_pkg.sv
// package for the cd+g graphics decoder: screen geometry, instruction codes,
// symbol extraction and color expansion helpers; no dependencies
package cdg_pkg;

    localparam int unsigned ScreenWidth  = 300;
    localparam int unsigned ScreenHeight = 216;
    localparam int unsigned Pixels       = ScreenWidth * ScreenHeight;
    localparam int unsigned AddrWidth    = $clog2(Pixels);
    localparam int unsigned XWidth       = 9;
    localparam int unsigned YWidth       = 8;
    localparam int unsigned TileW        = 6;
    localparam int unsigned TileH        = 12;
    localparam int unsigned BorderRight  = 294;
    localparam int unsigned BorderBottom = 204;

    localparam logic [5:0] CMD_GRAPHICS   = 6'h09;
    localparam logic [5:0] INST_PRESET    = 6'd1;
    localparam logic [5:0] INST_BORDER    = 6'd2;
    localparam logic [5:0] INST_TILE      = 6'd6;
    localparam logic [5:0] INST_TILE_XOR  = 6'd38;
    localparam logic [5:0] INST_SCROLL    = 6'd20;
    localparam logic [5:0] INST_SCROLL_CP = 6'd24;
    localparam logic [5:0] INST_CLUT_LO   = 6'd30;
    localparam logic [5:0] INST_CLUT_HI   = 6'd31;

    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    function automatic logic [5:0] sym(input logic [95:0] s, input logic [3:0] k);
        sym = s[6*k +: 6];
    endfunction

    function automatic logic [23:0] expand(input logic [11:0] c);
        expand = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
    endfunction

endpackage

>>> src/cdg_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module cdg_ram #(
    parameter int unsigned Width = 4,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> src/cd_graphics_command_decoder.sv
// cd+g graphics decoder top level: sequencer around the frame buffer ram
// depends on cdg_pkg and cdg_ram
//
// usage: pulse start with an item while busy is low. mode 0 applies one
// subcode packet, mode 1 reads one displayed pixel. every item gives exactly
// one result beat: done is high for one cycle with pixel_color and status,
// in the cycle right after the last busy cycle.
// a tile block reads then writes each of its 72 pixels in turn. a memory or
// border preset sweeps the whole 64800-entry buffer one entry a cycle (a
// memory preset only when bits 3:0 of symbol 1 are zero). a scroll runs a
// pass per moving axis: each pass copies the buffer into a scratch ram and
// then writes it back shifted, reading the scratch ram and then writing the
// frame buffer for each pixel; both rams are single-port.
// after reset a clearing pass writes zero to all 64800 frame-buffer entries
// with busy high; the color table resets at once. results cannot be held
// off, the receiver must take each beat when done is high.
module cd_graphics_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [5:0]  command,
    input  logic [5:0]  instruction,
    input  logic [47:0] symbols_low,
    input  logic [47:0] symbols_high,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        done,
    output logic [23:0] pixel_color,
    output logic        status
);
    import cdg_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_READ_WAIT, ST_READ_OUT, ST_FILL,
        ST_TILE_RD, ST_TILE_WR, ST_COPY, ST_SHIFT_RD, ST_SHIFT_WR, ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [95:0]      syms_reg;
    logic [5:0]       inst_reg;
    logic [8:0]       x_reg;
    logic [7:0]       y_reg;
    logic [3:0]       ti_reg;
    logic [2:0]       tj_reg;
    logic             vpass_reg;
    logic             vpend_reg;
    logic             status_reg;
    logic [23:0]      color_reg;
    logic             done_reg;
    logic [11:0]      clut_reg [16];

    // frame buffer and scratch ram ports
    logic                 fb_we, sc_we;
    logic [AddrWidth-1:0] fb_addr, sc_addr;
    logic [3:0]           fb_wdata, fb_rdata, sc_rdata;

    cdg_ram #(.Width(4), .Depth(Pixels)) u_fb (
        .clk(clk), .we(fb_we), .addr(fb_addr), .wdata(fb_wdata), .rdata(fb_rdata)
    );
    cdg_ram #(.Width(4), .Depth(Pixels)) u_scratch (
        .clk(clk), .we(sc_we), .addr(sc_addr), .wdata(fb_rdata), .rdata(sc_rdata)
    );

    logic [5:0] s0, s1, s2, s3;
    logic [3:0] fill;
    logic [1:0] hcmd, vcmd;
    logic [2:0] hsh;
    logic [3:0] vsh;
    logic       hact, vact;
    assign s0   = sym(syms_reg, 4'd0);
    assign s1   = sym(syms_reg, 4'd1);
    assign s2   = sym(syms_reg, 4'd2);
    assign s3   = sym(syms_reg, 4'd3);
    assign fill = s0[3:0];
    assign hcmd = s1[5:4];
    assign vcmd = s2[5:4];
    // 6 - (s1&7) wraps to 0 when over 6
    assign hsh  = (s1[2:0] == 3'd7) ? 3'd0 : 3'(3'd6 - s1[2:0]);
    assign vsh  = (s2[3:0] > 4'd12) ? 4'd0 : 4'(4'd12 - s2[3:0]);
    assign hact = (hcmd == DIR_FWD) || (hcmd == DIR_BACK);
    assign vact = (vcmd == DIR_FWD) || (vcmd == DIR_BACK);

    // address of a pixel from its row and column
    function automatic logic [AddrWidth-1:0] pix(input logic [7:0] y, input logic [8:0] x);
        pix = AddrWidth'(y * 17'(ScreenWidth)) + AddrWidth'(x);
    endfunction

    // tile position
    logic [8:0] tile_x;
    logic [7:0] tile_y;
    logic [5:0] tile_d;
    logic [3:0] tile_c;
    assign tile_x = 9'(s3 * 9'(TileW)) + 9'(tj_reg);
    assign tile_y = 8'(s2[4:0] * 8'(TileH)) + 8'(ti_reg);
    assign tile_d = sym(syms_reg, 4'(ti_reg + 4'd4));
    assign tile_c = tile_d[3'd5 - tj_reg] ? s1[3:0] : s0[3:0];

    // shift source for the current destination pixel
    logic [8:0] src_x;
    logic [7:0] src_y;
    logic       src_fill;
    always_comb
    begin
        src_x    = x_reg;
        src_y    = y_reg;
        src_fill = 1'b0;
        if (!vpass_reg)
        begin
            if (hcmd == DIR_FWD)
            begin
                if (x_reg < 9'(hsh))
                begin
                    src_x    = 9'(x_reg + 9'(ScreenWidth) - 9'(hsh));
                    src_fill = (inst_reg == INST_SCROLL);
                end
                else
                begin
                    src_x = 9'(x_reg - 9'(hsh));
                end
            end
            else
            begin
                if (x_reg < 9'(9'(ScreenWidth) - 9'(hsh)))
                begin
                    src_x = 9'(x_reg + 9'(hsh));
                end
                else
                begin
                    src_x    = 9'(x_reg - (9'(ScreenWidth) - 9'(hsh)));
                    src_fill = (inst_reg == INST_SCROLL);
                end
            end
        end
        else
        begin
            if (vcmd == DIR_FWD)
            begin
                if (y_reg < 8'(vsh))
                begin
                    src_y    = 8'(y_reg + 8'(ScreenHeight) - 8'(vsh));
                    src_fill = (inst_reg == INST_SCROLL);
                end
                else
                begin
                    src_y = 8'(y_reg - 8'(vsh));
                end
            end
            else
            begin
                if (y_reg < 8'(8'(ScreenHeight) - 8'(vsh)))
                begin
                    src_y = 8'(y_reg + 8'(vsh));
                end
                else
                begin
                    src_y    = 8'(y_reg - (8'(ScreenHeight) - 8'(vsh)));
                    src_fill = (inst_reg == INST_SCROLL);
                end
            end
        end
    end

    logic last_x, last_y, in_border;
    assign last_x    = (x_reg == 9'(ScreenWidth - 1));
    assign last_y    = (y_reg == 8'(ScreenHeight - 1));
    assign in_border = (x_reg < 9'(TileW)) || (x_reg >= 9'(BorderRight))
                    || (y_reg < 8'(TileH)) || (y_reg >= 8'(BorderBottom));

    // ram port drive
    always_comb
    begin
        fb_we    = 1'b0;
        fb_addr  = pix(y_reg, x_reg);
        fb_wdata = 4'd0;
        sc_we    = 1'b0;
        sc_addr  = pix(y_reg, x_reg);
        unique case (state_reg)
            ST_CLEAR:
            begin
                fb_we = 1'b1;
            end
            ST_FILL:
            begin
                fb_we    = (inst_reg == INST_PRESET) || in_border;
                fb_wdata = fill;
            end
            ST_TILE_RD:
            begin
                fb_addr = pix(tile_y, tile_x);
            end
            ST_TILE_WR:
            begin
                fb_addr  = pix(tile_y, tile_x);
                fb_we    = 1'b1;
                fb_wdata = (inst_reg == INST_TILE_XOR) ? (fb_rdata ^ tile_c) : tile_c;
            end
            ST_COPY:
            begin
                // write lags read: the scratch ram writes the previous address with the data read for it
                sc_we   = (x_reg != 9'd0) || (y_reg != 8'd0) || vpend_reg;
                if (vpend_reg)
                begin
                    sc_addr = pix(y_reg, x_reg);
                end
                else
                begin
                    sc_addr = (x_reg == 9'd0) ? pix(8'(y_reg - 8'd1), 9'(ScreenWidth - 1))
                                              : pix(y_reg, 9'(x_reg - 9'd1));
                end
            end
            ST_SHIFT_RD:
            begin
                sc_addr = pix(src_y, src_x);
            end
            ST_SHIFT_WR:
            begin
                fb_we    = 1'b1;
                fb_wdata = src_fill ? fill : sc_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            syms_reg   <= '0;
            inst_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            ti_reg     <= '0;
            tj_reg     <= '0;
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
            color_reg  <= '0;
            vpass_reg  <= 1'b0;
            vpend_reg  <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                clut_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR, ST_FILL:
                begin
                    if (last_x)
                    begin
                        x_reg <= '0;
                        if (last_y)
                        begin
                            y_reg     <= '0;
                            state_reg <= (state_reg == ST_CLEAR) ? ST_IDLE : ST_FINISH;
                        end
                        else
                        begin
                            y_reg <= y_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + 9'd1;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        syms_reg   <= {symbols_high, symbols_low};
                        inst_reg   <= instruction;
                        status_reg <= 1'b0;
                        color_reg  <= '0;
                        x_reg      <= '0;
                        y_reg      <= '0;
                        ti_reg     <= '0;
                        tj_reg     <= '0;
                        vpass_reg  <= 1'b0;
                        vpend_reg  <= 1'b0;
                        if (mode)
                        begin
                            x_reg <= pixel_x;
                            y_reg <= pixel_y;
                            if ((pixel_x >= 9'(ScreenWidth)) || (pixel_y >= 8'(ScreenHeight)))
                            begin
                                status_reg <= 1'b1;
                                state_reg  <= ST_FINISH;
                            end
                            else
                            begin
                                state_reg <= ST_READ;
                            end
                        end
                        else if (command != CMD_GRAPHICS)
                        begin
                            status_reg <= 1'b1;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                            unique case (instruction)
                                INST_PRESET:
                                begin
                                    if (symbols_low[9:6] == 4'd0)
                                    begin
                                        state_reg <= ST_FILL;
                                    end
                                end
                                INST_BORDER:
                                begin
                                    state_reg <= ST_FILL;
                                end
                                INST_TILE, INST_TILE_XOR:
                                begin
                                    if ((symbols_low[16:12] > 5'd17)
                                        || (symbols_low[23:18] > 6'd49))
                                    begin
                                        status_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_TILE_RD;
                                    end
                                end
                                INST_SCROLL, INST_SCROLL_CP:
                                begin
                                    if ((symbols_low[11:10] == DIR_FWD)
                                        || (symbols_low[11:10] == DIR_BACK))
                                    begin
                                        state_reg <= ST_COPY;
                                    end
                                    else if ((symbols_low[17:16] == DIR_FWD)
                                        || (symbols_low[17:16] == DIR_BACK))
                                    begin
                                        vpass_reg <= 1'b1;
                                        state_reg <= ST_COPY;
                                    end
                                end
                                INST_CLUT_LO, INST_CLUT_HI:
                                begin
                                    // entry i takes symbol 2i as high half, 2i+1 as low
                                    for (int i = 0; i < 8; i++)
                                    begin
                                        clut_reg[{instruction[0], 3'(i)}] <=
                                            {sym({symbols_high, symbols_low}, 4'(2 * i)),
                                             sym({symbols_high, symbols_low}, 4'(2 * i + 1))};
                                    end
                                end
                                default:
                                begin
                                    status_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_READ_WAIT;
                end
                ST_READ_WAIT:
                begin
                    state_reg <= ST_READ_OUT;
                end
                ST_READ_OUT:
                begin
                    color_reg <= expand(clut_reg[fb_rdata]);
                    state_reg <= ST_FINISH;
                end
                ST_TILE_RD:
                begin
                    state_reg <= ST_TILE_WR;
                end
                ST_TILE_WR:
                begin
                    state_reg <= ST_TILE_RD;
                    if (tj_reg == 3'(TileW - 1))
                    begin
                        tj_reg <= '0;
                        if (ti_reg == 4'(TileH - 1))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        ti_reg <= ti_reg + 4'd1;
                    end
                    else
                    begin
                        tj_reg <= tj_reg + 3'd1;
                    end
                end
                ST_COPY:
                begin
                    // after the last address, vpend_reg holds the walk so the last entry is written
                    if (vpend_reg)
                    begin
                        vpend_reg <= 1'b0;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        state_reg <= ST_SHIFT_RD;
                    end
                    else if (last_x && last_y)
                    begin
                        vpend_reg <= 1'b1;
                    end
                    else if (last_x)
                    begin
                        x_reg <= '0;
                        y_reg <= y_reg + 8'd1;
                    end
                    else
                    begin
                        x_reg <= x_reg + 9'd1;
                    end
                end
                ST_SHIFT_RD:
                begin
                    state_reg <= ST_SHIFT_WR;
                end
                ST_SHIFT_WR:
                begin
                    state_reg <= ST_SHIFT_RD;
                    if (last_x)
                    begin
                        x_reg <= '0;
                        if (last_y)
                        begin
                            y_reg <= '0;
                            if (!vpass_reg && vact)
                            begin
                                vpass_reg <= 1'b1;
                                state_reg <= ST_COPY;
                            end
                            else
                            begin
                                state_reg <= ST_FINISH;
                            end
                        end
                        else
                        begin
                            y_reg <= y_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + 9'd1;
                    end
                end
                ST_FINISH:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign pixel_color = color_reg;
    assign status      = status_reg;
endmodule

>>> src/cdg_checker.sv
// port-level checks for the cd+g decoder and the bind that attaches them
// depends on cd_graphics_command_decoder
module cdg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [23:0] pixel_color,
    input logic        status
);
    // an accepted item makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result beat ends the item
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while still busy");

    // results are single-cycle beats
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result held more than one cycle");

    // an item flagged by status (a failed read or a refused packet) returns black
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (pixel_color == 24'd0))
        else $error("ignored item returned a color");
endmodule

bind cd_graphics_command_decoder cdg_checker u_cdg_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .pixel_color(pixel_color), .status(status)
);
